// ===== rtl/mpcrc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpcrc_pkg: shared types and CRC functions of the multi-profile CRC engine
// Profile codes, per-profile constants, the command word passed from the
// front to the back, and the unrolled one-byte CRC updates.
// ----------------------------------------------------------------------------
package mpcrc_pkg;

    // Profile codes carried on the mode field
    localparam logic [2:0] MODE_CRC8        = 3'd0;
    localparam logic [2:0] MODE_CRC8H2F     = 3'd1;
    localparam logic [2:0] MODE_CRC16_CCITT = 3'd2;
    localparam logic [2:0] MODE_CRC16_ARC   = 3'd3;
    localparam logic [2:0] MODE_CRC32       = 3'd4;
    localparam logic [2:0] MODE_CRC32P4     = 3'd5;

    // Generator polynomials (reflected form for the LSB-first profiles)
    localparam logic [7:0]  POLY_CRC8        = 8'h1D;
    localparam logic [7:0]  POLY_CRC8H2F     = 8'h2F;
    localparam logic [15:0] POLY_CRC16_CCITT = 16'h1021;
    localparam logic [31:0] POLY_CRC16_ARC   = 32'h0000_A001;
    localparam logic [31:0] POLY_CRC32       = 32'hEDB8_8320;
    localparam logic [31:0] POLY_CRC32P4     = 32'hC8DF_352F;

    // Queue depth between stages and on the result side
    localparam logic [1:0] QUEUE_DEPTH = 2'd2;

    // Classified item handed from the front to the back
    typedef struct packed {
        logic        mode_ok;     // profile code is defined
        logic [2:0]  mode;
        logic        load;        // reload the register before the byte
        logic [31:0] load_value;  // already masked to the profile width
        logic        present;
        logic [7:0]  data;
    } crc_cmd_t;

    function automatic logic mode_valid(input logic [2:0] mode);
        return (mode <= MODE_CRC32P4);
    endfunction

    function automatic logic [31:0] prof_mask(input logic [2:0] mode);
        logic [31:0] m;
        unique case (mode)
            MODE_CRC8, MODE_CRC8H2F:          m = 32'h0000_00FF;
            MODE_CRC16_CCITT, MODE_CRC16_ARC: m = 32'h0000_FFFF;
            MODE_CRC32, MODE_CRC32P4:         m = 32'hFFFF_FFFF;
            default:                          m = 32'h0000_0000;
        endcase
        return m;
    endfunction

    function automatic logic [31:0] prof_init(input logic [2:0] mode);
        logic [31:0] v;
        unique case (mode)
            MODE_CRC8, MODE_CRC8H2F:  v = 32'h0000_00FF;
            MODE_CRC16_CCITT:         v = 32'h0000_FFFF;
            MODE_CRC16_ARC:           v = 32'h0000_0000;
            MODE_CRC32, MODE_CRC32P4: v = 32'hFFFF_FFFF;
            default:                  v = 32'h0000_0000;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] prof_xorout(input logic [2:0] mode);
        logic [31:0] v;
        unique case (mode)
            MODE_CRC8, MODE_CRC8H2F:          v = 32'h0000_00FF;
            MODE_CRC16_CCITT, MODE_CRC16_ARC: v = 32'h0000_0000;
            MODE_CRC32, MODE_CRC32P4:         v = 32'hFFFF_FFFF;
            default:                          v = 32'h0000_0000;
        endcase
        return v;
    endfunction

    // MSB-first byte update, 8-bit register
    function automatic logic [7:0] fold_msb8(input logic [7:0] crc, input logic [7:0] data,
                                             input logic [7:0] poly);
        logic [7:0] r;
        r = crc ^ data;
        for (int i = 0; i < 8; i++) begin
            r = r[7] ? ((r << 1) ^ poly) : (r << 1);
        end
        return r;
    endfunction

    // MSB-first byte update, 16-bit register
    function automatic logic [15:0] fold_msb16(input logic [15:0] crc, input logic [7:0] data,
                                               input logic [15:0] poly);
        logic [15:0] r;
        r = crc ^ {data, 8'h00};
        for (int i = 0; i < 8; i++) begin
            r = r[15] ? ((r << 1) ^ poly) : (r << 1);
        end
        return r;
    endfunction

    // Reflected byte update; upper bits stay clear for a narrower register
    function automatic logic [31:0] fold_refl(input logic [31:0] crc, input logic [7:0] data,
                                              input logic [31:0] poly);
        logic [31:0] r;
        r = crc ^ {24'h0, data};
        for (int i = 0; i < 8; i++) begin
            r = r[0] ? ((r >> 1) ^ poly) : (r >> 1);
        end
        return r;
    endfunction

    // One byte through the selected profile; crc is already masked
    function automatic logic [31:0] crc_step(input logic [2:0] mode, input logic [31:0] crc,
                                             input logic [7:0] data);
        logic [31:0] r;
        unique case (mode)
            MODE_CRC8:        r = {24'h0, fold_msb8(crc[7:0], data, POLY_CRC8)};
            MODE_CRC8H2F:     r = {24'h0, fold_msb8(crc[7:0], data, POLY_CRC8H2F)};
            MODE_CRC16_CCITT: r = {16'h0, fold_msb16(crc[15:0], data, POLY_CRC16_CCITT)};
            MODE_CRC16_ARC:   r = fold_refl({16'h0, crc[15:0]}, data, POLY_CRC16_ARC);
            MODE_CRC32:       r = fold_refl(crc, data, POLY_CRC32);
            MODE_CRC32P4:     r = fold_refl(crc, data, POLY_CRC32P4);
            default:          r = crc;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/mpcrc_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpcrc_front: input side of the CRC engine
// Takes input transfers, decodes the profile and the reload value, and
// holds the classified commands in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module mpcrc_front
    import mpcrc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [2:0]  mode,
    input  wire logic [7:0]  data_byte,
    input  wire logic        byte_present,
    input  wire logic        start_of_message,
    input  wire logic        resume,
    input  wire logic [31:0] start_value,
    output crc_cmd_t         cmd,
    output logic             cmd_valid,
    input  wire logic        cmd_pop
);

    crc_cmd_t   slot_reg [2];
    crc_cmd_t   cmd_new;
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       in_xfer;
    logic       out_xfer;

    // Classify the incoming item
    always_comb
    begin
        cmd_new.mode_ok    = mode_valid(mode);
        cmd_new.mode       = mode;
        cmd_new.load       = start_of_message;
        cmd_new.load_value = resume ? ((start_value ^ prof_xorout(mode)) & prof_mask(mode))
                                    : prof_init(mode);
        cmd_new.present    = byte_present;
        cmd_new.data       = data_byte;
    end

    assign full      = (count_reg == QUEUE_DEPTH);
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = slot_reg[rd_ptr_reg];
    assign in_xfer   = push && !full;
    assign out_xfer  = cmd_pop && cmd_valid;

    // Queue pointers and fill count
    always_comb
    begin
        wr_ptr_next = in_xfer  ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = out_xfer ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (in_xfer && !out_xfer)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (out_xfer && !in_xfer)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Command storage
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            slot_reg[wr_ptr_reg] <= cmd_new;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/mpcrc_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpcrc_back: CRC datapath and result queue
// Pulls one command a cycle while the result queue has room, reloads and folds the byte into the CRC
// register, and queues the finalized value in a two-entry result queue.
// ----------------------------------------------------------------------------
module mpcrc_back
    import mpcrc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire crc_cmd_t    cmd,
    input  wire logic        cmd_valid,
    output logic             cmd_pop,
    output logic             empty,
    input  wire logic        pop,
    output logic [31:0]      crc_value
);

    logic [31:0] crc_reg, crc_next;
    logic [31:0] res_reg [2];
    logic [31:0] res_new;
    logic [31:0] base;
    logic [31:0] mask;
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        out_xfer;

    assign empty     = (count_reg == 2'd0);
    assign crc_value = res_reg[rd_ptr_reg];
    assign out_xfer  = pop && !empty;

    // Take a command when the result queue has room
    assign cmd_pop = cmd_valid && ((count_reg != QUEUE_DEPTH) || out_xfer);

    // CRC update: reload, then fold the byte
    always_comb
    begin
        mask     = prof_mask(cmd.mode);
        base     = cmd.load ? cmd.load_value : (crc_reg & mask);
        crc_next = cmd.present ? crc_step(cmd.mode, base, cmd.data) : base;
        res_new  = cmd.mode_ok ? ((crc_next ^ prof_xorout(cmd.mode)) & mask) : 32'h0;
    end

    // Result queue pointers and fill count
    always_comb
    begin
        wr_ptr_next = cmd_pop  ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = out_xfer ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (cmd_pop && !out_xfer)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (out_xfer && !cmd_pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg    <= 32'h0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            // undefined profiles leave the register untouched
            if (cmd_pop && cmd.mode_ok)
            begin
                crc_reg <= crc_next;
            end
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Result storage
    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            res_reg[wr_ptr_reg] <= res_new;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/multi_profile_crc_engine_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// With both queues empty, an input transfer's item is registered in the command queue and its
//   result in the result queue (empty low); each command or result waiting ahead delays it.
// Throughput: one item per cycle while results are popped, set by the combinational byte update.
// Reset (rst_n low, asynchronous): both queues empty, CRC register cleared to zero.
// ----------------------------------------------------------------------------
// multi_profile_crc_engine_core: six-profile byte-wise CRC engine
// Front end classifies items into a command queue; back end runs the CRC
// register and queues results.
// ----------------------------------------------------------------------------
module multi_profile_crc_engine_core
    import mpcrc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [2:0]  mode,
    input  wire logic [7:0]  data_byte,
    input  wire logic        byte_present,
    input  wire logic        start_of_message,
    input  wire logic        resume,
    input  wire logic [31:0] start_value,
    output logic             empty,
    input  wire logic        pop,
    output logic [31:0]      crc_value
);

    crc_cmd_t cmd;
    logic     cmd_valid;
    logic     cmd_pop;

    mpcrc_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .push             (push),
        .full             (full),
        .mode             (mode),
        .data_byte        (data_byte),
        .byte_present     (byte_present),
        .start_of_message (start_of_message),
        .resume           (resume),
        .start_value      (start_value),
        .cmd              (cmd),
        .cmd_valid        (cmd_valid),
        .cmd_pop          (cmd_pop)
    );

    mpcrc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .empty     (empty),
        .pop       (pop),
        .crc_value (crc_value)
    );

endmodule
`default_nettype wire

// ===== rtl/mpcrc_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpcrc_checker: port-level checks of the CRC engine
// Watches the queue-style ports of the top level; attached by bind.
// ----------------------------------------------------------------------------
module mpcrc_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        push,
    input wire logic        full,
    input wire logic        empty,
    input wire logic        pop,
    input wire logic [31:0] crc_value
);

    // A waiting result is not withdrawn without a pop
    a_res_held: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> !empty)
        else $error("result dropped without a pop transfer");

    // A waiting result keeps its value until taken
    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> $stable(crc_value))
        else $error("result changed while waiting");

    // The input side only fills up through a push transfer
    a_full_cause: assert property (@(posedge clk) disable iff (!rst_n)
        (!full && !push) |=> !full)
        else $error("full rose without a push transfer");

    // With no result waiting, a new item shows once it has passed the command and result queues
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full && empty) |-> ##2 !empty)
        else $error("result missing two cycles after transfer");

endmodule

bind multi_profile_crc_engine_core mpcrc_checker u_mpcrc_checker (.*);
`default_nettype wire

// ===== tb/multi_profile_crc_engine_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_profile_crc_engine_core_tb: self-checking bench for the CRC engine
// Streams byte items through the queue-style input and checks every popped
// CRC against a bit-serial model of all six profiles. The items are a short
// directed list, then random messages mixed with noise. Both sides stall at
// random, and the sender waits at least once for all results to drain.
// ----------------------------------------------------------------------------
module multi_profile_crc_engine_core_tb;
    import mpcrc_pkg::*;

    // Mode codes with no profile behind them
    localparam logic [2:0] MODE_SPARE_A = 3'd6;
    localparam logic [2:0] MODE_SPARE_B = 3'd7;

    localparam int RESET_CYCLES   = 11;
    localparam int LIVE_ITEMS     = 1650;
    localparam int STALL_PERCENT  = 7;
    localparam int QUIET_FROM     = 700;
    localparam int QUIET_TO       = 1000;
    localparam int DRAIN_AT       = 800;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int TAIL_CYCLES    = 8;
    localparam int PRINT_LIMIT    = 200;

    typedef struct packed {
        logic [31:0] mask;
        logic [31:0] poly;
        logic [31:0] init;
        logic [31:0] xorout;
        logic        lsb_first;
    } crc_profile_t;

    typedef struct packed {
        logic        drain_first;   // hold off until every result is back
        logic [2:0]  mode;
        logic [7:0]  data;
        logic        present;
        logic        start;
        logic        resume;
        logic [31:0] sv;
    } crc_item_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [2:0]  mode;
    logic [7:0]  data_byte;
    logic        byte_present;
    logic        start_of_message;
    logic        resume;
    logic [31:0] start_value;
    logic        empty;
    logic        pop;
    logic [31:0] crc_value;

    crc_item_t   crc_items[$];
    logic [31:0] expected_crcs[$];
    logic [31:0] crc_state;
    logic        drain_next;
    logic        in_taken;
    int          accepted_items;
    int          idle_cycles;
    int          mismatch_count;

    multi_profile_crc_engine_core dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .push             (push),
        .full             (full),
        .mode             (mode),
        .data_byte        (data_byte),
        .byte_present     (byte_present),
        .start_of_message (start_of_message),
        .resume           (resume),
        .start_value      (start_value),
        .empty            (empty),
        .pop              (pop),
        .crc_value        (crc_value)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Profile table: width mask, polynomial, init, final XOR, bit order
    function automatic crc_profile_t profile_of(input logic [2:0] m);
        crc_profile_t p;
        case (m)
            MODE_CRC8:        p = {32'hFF, 32'h1D, 32'hFF, 32'hFF, 1'b0};
            MODE_CRC8H2F:     p = {32'hFF, 32'h2F, 32'hFF, 32'hFF, 1'b0};
            MODE_CRC16_CCITT: p = {32'hFFFF, 32'h1021, 32'hFFFF, 32'h0, 1'b0};
            MODE_CRC16_ARC:   p = {32'hFFFF, 32'hA001, 32'h0, 32'h0, 1'b1};
            MODE_CRC32:       p = {32'hFFFF_FFFF, 32'hEDB8_8320, 32'hFFFF_FFFF,
                                   32'hFFFF_FFFF, 1'b1};
            MODE_CRC32P4:     p = {32'hFFFF_FFFF, 32'hC8DF_352F, 32'hFFFF_FFFF,
                                   32'hFFFF_FFFF, 1'b1};
            default:          p = '0;
        endcase
        return p;
    endfunction

    // Bit-serial LFSR: one data bit per shift, feedback from the outgoing bit
    function automatic logic [31:0] shift_byte(input crc_profile_t p, input logic [31:0] r,
                                               input logic [7:0] d);
        logic [31:0] top;
        logic        fb;
        top = p.mask ^ (p.mask >> 1);
        for (int i = 0; i < 8; i++)
        begin
            if (p.lsb_first)
            begin
                fb = r[0] ^ d[i];
                r  = r >> 1;
            end
            else
            begin
                fb = ((r & top) != 0) ^ d[7 - i];
                r  = (r << 1) & p.mask;
            end
            if (fb)
                r = r ^ p.poly;
        end
        return r & p.mask;
    endfunction

    // Expected CRC output of one item; advances the running register
    function automatic logic [31:0] predict_crc(input crc_item_t it);
        crc_profile_t p;
        logic [31:0]  r;
        if (it.mode > MODE_CRC32P4)
            return 32'h0;
        p = profile_of(it.mode);
        r = crc_state & p.mask;
        if (it.start)
            r = it.resume ? ((it.sv ^ p.xorout) & p.mask) : p.init;
        if (it.present)
            r = shift_byte(p, r, it.data);
        crc_state = r;
        return (r ^ p.xorout) & p.mask;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < PRINT_LIMIT)
            $display("ERROR %0t: %s: crc_value got %08h want %08h", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic add_item(input logic [2:0] m, input logic [7:0] d, input logic pres,
                            input logic st, input logic res, input logic [31:0] sv);
        crc_item_t it;
        it.drain_first = drain_next;
        it.mode        = m;
        it.data        = d;
        it.present     = pres;
        it.start       = st;
        it.resume      = res;
        it.sv          = sv;
        crc_items.push_back(it);
        drain_next = 1'b0;
    endtask

    // Monitor: check popped results, predict accepted items, watchdog
    always @(posedge clk)
    begin : result_monitor
        crc_item_t   it;
        logic        out_taken;
        logic [31:0] want;
        if (rst_n)
        begin
            in_taken  = push && !full;
            out_taken = pop && !empty;
            if (out_taken)
            begin
                if (expected_crcs.size() == 0)
                    report_mismatch("result with none expected", crc_value, 32'h0);
                else
                begin
                    want = expected_crcs.pop_front();
                    if (crc_value !== want)
                        report_mismatch("wrong crc", crc_value, want);
                end
            end
            if (in_taken)
            begin
                it.drain_first = 1'b0;
                it.mode        = mode;
                it.data        = data_byte;
                it.present     = byte_present;
                it.start       = start_of_message;
                it.resume      = resume;
                it.sv          = start_value;
                expected_crcs.push_back(predict_crc(it));
                accepted_items++;
            end
            if (in_taken || out_taken)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Driver: present the next item at the falling edge, with random gaps
    always @(negedge clk)
    begin : item_driver
        crc_item_t it;
        logic      quiet;
        logic      send;
        quiet = (accepted_items >= QUIET_FROM) && (accepted_items < QUIET_TO);
        if (!rst_n)
        begin
            push <= 1'b0;
            pop  <= 1'b0;
        end
        else
        begin
            pop <= quiet || ($urandom_range(0, 99) >= STALL_PERCENT);
            if (!push || in_taken)
            begin
                send = 1'b0;
                if (crc_items.size() != 0)
                begin
                    if (crc_items[0].drain_first && (expected_crcs.size() != 0))
                        send = 1'b0;
                    else if (!quiet && ($urandom_range(0, 99) < STALL_PERCENT))
                        send = 1'b0;
                    else
                        send = 1'b1;
                end
                push <= send;
                if (send)
                begin
                    it = crc_items.pop_front();
                    mode             <= it.mode;
                    data_byte        <= it.data;
                    byte_present     <= it.present;
                    start_of_message <= it.start;
                    resume           <= it.resume;
                    start_value      <= it.sv;
                end
            end
        end
    end

    // Stimulus, reset and end of run
    initial
    begin : stimulus
        int          live;
        int          len;
        logic [2:0]  m;
        logic [31:0] sv;
        rst_n            = 1'b0;
        push             = 1'b0;
        pop              = 1'b0;
        mode             = MODE_CRC8;
        data_byte        = 8'h00;
        byte_present     = 1'b0;
        start_of_message = 1'b0;
        resume           = 1'b0;
        start_value      = 32'h0;
        crc_state        = 32'h0;
        drain_next       = 1'b0;
        in_taken         = 1'b0;
        accepted_items   = 0;
        idle_cycles      = 0;
        mismatch_count   = 0;

        // Directed: every profile, byte extremes, resume, empty steps
        add_item(MODE_CRC8,        8'h00, 1'b1, 1'b1, 1'b0, 32'h0);
        add_item(MODE_CRC8,        8'hFF, 1'b1, 1'b0, 1'b0, 32'h0);
        add_item(MODE_CRC8H2F,     8'h5A, 1'b1, 1'b1, 1'b0, 32'h0);
        add_item(MODE_CRC16_CCITT, 8'hFF, 1'b1, 1'b1, 1'b0, 32'h0);
        add_item(MODE_CRC16_ARC,   8'h01, 1'b1, 1'b1, 1'b0, 32'h0);
        add_item(MODE_CRC32,       8'h80, 1'b1, 1'b1, 1'b0, 32'h0);
        add_item(MODE_CRC32P4,     8'hA5, 1'b1, 1'b1, 1'b0, 32'h0);
        add_item(MODE_CRC32,       8'h00, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF);
        add_item(MODE_CRC32P4,     8'h00, 1'b0, 1'b1, 1'b1, 32'h0);
        // zero-length message
        add_item(MODE_CRC8,        8'h00, 1'b0, 1'b1, 1'b0, 32'h0);
        // spare codes must leave the register alone and return zero
        add_item(MODE_SPARE_A,     8'hC3, 1'b1, 1'b0, 1'b0, 32'h0);
        add_item(MODE_SPARE_B,     8'hFF, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF);
        // profile switch mid-message, reload values cut to the new width
        add_item(MODE_CRC32,       8'h12, 1'b1, 1'b0, 1'b0, 32'h0);
        add_item(MODE_CRC16_CCITT, 8'h31, 1'b1, 1'b1, 1'b1, 32'hDEAD_BEEF);
        add_item(MODE_CRC16_ARC,   8'h00, 1'b0, 1'b1, 1'b1, 32'h1234_ABCD);
        add_item(MODE_CRC8,        8'h7E, 1'b1, 1'b1, 1'b1, 32'hFFFF_FF00);
        // no reload, no byte
        add_item(MODE_CRC16_CCITT, 8'h00, 1'b0, 1'b0, 1'b0, 32'h0);
        // resume without start is ignored
        add_item(MODE_CRC8H2F,     8'h3C, 1'b1, 1'b0, 1'b1, 32'hAAAA_5555);
        add_item(MODE_CRC32,       8'hFF, 1'b1, 1'b1, 1'b0, 32'h0);
        add_item(MODE_CRC32P4,     8'h01, 1'b1, 1'b0, 1'b1, 32'h8000_0001);
        add_item(MODE_CRC16_ARC,   8'hFF, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF);
        live = 19;

        // Random: mostly well-formed messages, some noise items
        drain_next = 1'b1;
        while (live < LIVE_ITEMS)
        begin
            if ((live >= DRAIN_AT) && (live < DRAIN_AT + 12) && !drain_next)
                drain_next = (crc_items.size() % 97) == 0;
            if ($urandom_range(0, 9) == 0)
            begin
                m = 3'($urandom_range(0, 7));
                add_item(m, 8'($urandom), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom);
                if (m <= MODE_CRC32P4)
                    live++;
            end
            else
            begin
                m   = 3'($urandom_range(0, 5));
                len = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 40)
                                                   : $urandom_range(1, 12);
                case ($urandom_range(0, 5))
                    0:       sv = 32'h0;
                    1:       sv = 32'hFFFF_FFFF;
                    default: sv = $urandom;
                endcase
                add_item(m, 8'($urandom), $urandom_range(0, 9) != 0, 1'b1,
                         $urandom_range(0, 2) == 0, sv);
                live++;
                for (int i = 1; i < len; i++)
                begin
                    add_item(m, 8'($urandom), $urandom_range(0, 19) != 0, 1'b0,
                             1'($urandom_range(0, 1)), $urandom);
                    live++;
                end
            end
        end
        // midpoint drain, in case the pick above missed
        if (crc_items.size() > 100)
            crc_items[crc_items.size() / 2].drain_first = 1'b1;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Wait for all items to go in and all results to come out
        while ((crc_items.size() != 0) || push)
            @(posedge clk);
        while (expected_crcs.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
